// ----- hw/rtl/impmp_pkg.sv -----
package impmp_pkg;

	localparam int DATA_BITS        = 16;
	localparam int CORDIC_STEPS     = 16;
	localparam int CORDIC_PER_STAGE = 2;
	localparam int SQRT_BITS        = 24;
	localparam int SQRT_PER_STAGE   = 3;
	localparam int CORDIC_STAGES    = (CORDIC_STEPS + CORDIC_PER_STAGE - 1) / CORDIC_PER_STAGE;
	localparam int SQRT_STAGES      = (SQRT_BITS + SQRT_PER_STAGE - 1) / SQRT_PER_STAGE;
	localparam int FRONT_STAGES     = (CORDIC_STAGES > SQRT_STAGES) ? CORDIC_STAGES : SQRT_STAGES;
	localparam int DIV_STEPS        = 32;
	localparam int LATENCY          = 1 + FRONT_STAGES + 2 + DIV_STEPS + 1;

	localparam logic [2:0] REG_CALIBRATED = 3'd0;
	localparam logic [2:0] REG_CAL_MODE   = 3'd1;
	localparam logic [2:0] REG_GAIN       = 3'd2;
	localparam logic [2:0] REG_GAIN_RATE  = 3'd3;
	localparam logic [2:0] REG_START_FREQ = 3'd4;

	localparam logic [23:0] ANGLE_MAX  = 24'd5898240;
	localparam logic signed [16:0] DEG_90  = 17'sd11520;
	localparam logic signed [16:0] DEG_180 = 17'sd23040;
	localparam logic signed [16:0] DEG_360 = 17'sd46080;

	typedef struct packed {
		logic        calibrated;
		logic        cal_mode;
		logic [47:0] gain_factor;
		logic [47:0] gain_rate;
		logic [16:0] start_frequency;
	} cfg_t;

	typedef struct packed {
		logic [2*SQRT_BITS-1:0] n;
		logic [25:0]            rem;
		logic [SQRT_BITS-1:0]   root;
		logic signed [26:0]     x;
		logic signed [26:0]     y;
		logic signed [25:0]     z;
		logic                   re_zero;
		logic                   re_neg;
		logic                   im_zero;
		logic                   im_neg;
		logic [64:0]            b;
		logic                   same;
		logic [65:0]            p;
		logic                   p_ok;
	} front_t;

	typedef struct packed {
		logic [23:0]        mag;
		logic signed [16:0] phase;
		logic [89:0]        d;
		logic               ok;
	} mul_t;

	typedef struct packed {
		logic [23:0]        mag;
		logic signed [16:0] phase;
		logic [89:0]        d;
		logic [90:0]        r;
		logic [31:0]        q;
		logic               ok;
	} div_t;

	// atan(2^-i) in degrees scaled by 2^16
	function automatic logic [21:0] atan_deg(input logic [4:0] i);
		logic [21:0] v;
		unique case (i)
			5'd0:  v = 22'd2949120;
			5'd1:  v = 22'd1740967;
			5'd2:  v = 22'd919879;
			5'd3:  v = 22'd466945;
			5'd4:  v = 22'd234379;
			5'd5:  v = 22'd117304;
			5'd6:  v = 22'd58666;
			5'd7:  v = 22'd29335;
			5'd8:  v = 22'd14668;
			5'd9:  v = 22'd7334;
			5'd10: v = 22'd3667;
			5'd11: v = 22'd1833;
			5'd12: v = 22'd917;
			5'd13: v = 22'd458;
			5'd14: v = 22'd229;
			5'd15: v = 22'd115;
			5'd16: v = 22'd57;
			5'd17: v = 22'd29;
			5'd18: v = 22'd14;
			5'd19: v = 22'd7;
			5'd20: v = 22'd4;
			5'd21: v = 22'd2;
			5'd22: v = 22'd1;
			default: v = 22'd0;
		endcase
		return v;
	endfunction

endpackage

// ----- hw/rtl/impmp_front.sv -----
module impmp_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_vld,
	input  logic [15:0]          real_part,
	input  logic [15:0]          imag_part,
	input  logic [16:0]          frequency,
	input  impmp_pkg::cfg_t      cfg,
	output logic                 out_vld,
	output impmp_pkg::front_t    out
);

	localparam int NS = impmp_pkg::FRONT_STAGES;
	localparam int DB = impmp_pkg::DATA_BITS;

	impmp_pkg::front_t ini;
	impmp_pkg::front_t in_s1;
	logic              vld_s1;
	impmp_pkg::front_t src [NS+1];
	impmp_pkg::front_t nxt [NS];
	impmp_pkg::front_t stg_s [NS];
	logic              vld_s [NS];

	always_comb begin : entry
		logic signed [DB-1:0] re;
		logic signed [DB-1:0] im;
		logic [DB-1:0]        are;
		logic [DB-1:0]        aim;
		logic [2*DB:0]        sq;
		logic signed [17:0]   df;
		logic [16:0]          ad;
		logic [47:0]          ar;
		re  = real_part[DB-1:0];
		im  = imag_part[DB-1:0];
		are = re[DB-1] ? DB'(-re) : DB'(re);
		aim = im[DB-1] ? DB'(-im) : DB'(im);
		sq  = (2*DB+1)'(are * are) + (2*DB+1)'(aim * aim);
		ini = '0;
		ini.n    = (2*impmp_pkg::SQRT_BITS)'(sq) << 16;
		ini.x    = $signed(27'({are, 8'b0}));
		ini.y    = $signed(27'({aim, 8'b0}));
		ini.re_zero = (re == '0);
		ini.re_neg  = re[DB-1];
		ini.im_zero = (im == '0);
		ini.im_neg  = im[DB-1];
		df  = $signed({1'b0, frequency}) - $signed({1'b0, cfg.start_frequency});
		ad  = df[17] ? 17'(-df) : 17'(df);
		ar  = cfg.gain_rate[47] ? 48'(-$signed(cfg.gain_rate)) : cfg.gain_rate;
		ini.b    = 65'(ar * ad);
		ini.same = (cfg.gain_rate[47] == df[17]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		in_s1 <= ini;
	end

	assign src[0] = in_s1;

	for (genvar s = 0; s < NS; s++) begin : g_stage
		always_comb begin : step
			impmp_pkg::front_t w;
			logic [27:0]        rsh;
			logic [27:0]        t;
			logic signed [26:0] dx;
			logic signed [26:0] dy;
			logic [65:0]        pb;
			w = src[s];
			for (int c = 0; c < impmp_pkg::CORDIC_PER_STAGE; c++) begin
				if (impmp_pkg::CORDIC_PER_STAGE*s + c < impmp_pkg::CORDIC_STEPS) begin
					dx = w.y >>> (impmp_pkg::CORDIC_PER_STAGE*s + c);
					dy = w.x >>> (impmp_pkg::CORDIC_PER_STAGE*s + c);
					if (!w.y[26]) begin
						w.x = w.x + dx;
						w.y = w.y - dy;
						w.z = w.z + $signed({4'b0, impmp_pkg::atan_deg(
							5'(impmp_pkg::CORDIC_PER_STAGE*s + c))});
					end else begin
						w.x = w.x - dx;
						w.y = w.y + dy;
						w.z = w.z - $signed({4'b0, impmp_pkg::atan_deg(
							5'(impmp_pkg::CORDIC_PER_STAGE*s + c))});
					end
				end
			end
			// one root bit per bit pair of the radicand, top first
			for (int c = 0; c < impmp_pkg::SQRT_PER_STAGE; c++) begin
				if (impmp_pkg::SQRT_PER_STAGE*s + c < impmp_pkg::SQRT_BITS) begin
					rsh = {w.rem, w.n[2*(impmp_pkg::SQRT_BITS-1-
						(impmp_pkg::SQRT_PER_STAGE*s + c)) +: 2]};
					t   = {2'b00, w.root, 2'b01};
					if (rsh >= t) begin
						rsh    = rsh - t;
						w.root = {w.root[impmp_pkg::SQRT_BITS-2:0], 1'b1};
					end else begin
						w.root = {w.root[impmp_pkg::SQRT_BITS-2:0], 1'b0};
					end
					w.rem = rsh[25:0];
				end
			end
			if (s == 0) begin
				pb     = {2'b00, cfg.gain_factor, 16'b0};
				w.p    = pb;
				w.p_ok = 1'b1;
				if (cfg.cal_mode) begin
					if (w.same) begin
						w.p = pb + 66'(w.b);
					end else if (66'(w.b) <= pb) begin
						w.p = pb - 66'(w.b);
					end else begin
						w.p_ok = 1'b0;
					end
				end
			end
			nxt[s] = w;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[s] <= 1'b0;
			end else begin
				vld_s[s] <= (s == 0) ? vld_s1 : vld_s[(s == 0) ? 0 : s-1];
			end
		end

		always_ff @(posedge clk) begin
			stg_s[s] <= nxt[s];
		end

		assign src[s+1] = stg_s[s];
	end

	assign out_vld = vld_s[NS-1];
	assign out     = src[NS];

endmodule

// ----- hw/rtl/impmp_mul.sv -----
module impmp_mul (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_vld,
	input  impmp_pkg::front_t    fr,
	output logic                 out_vld,
	output impmp_pkg::mul_t      out
);

	logic               vld_s1;
	logic [23:0]        mag_s1;
	logic signed [16:0] phase_s1;
	logic [56:0]        plo_s1;
	logic [56:0]        phi_s1;
	logic               pok_s1;
	logic               vld_s2;
	impmp_pkg::mul_t    res_s2;

	logic signed [16:0] phase_w;
	logic [89:0]        d_w;

	always_comb begin : phase_calc
		logic [23:0]        zc;
		logic [14:0]        tm;
		logic signed [16:0] term;
		logic               im_pos;
		im_pos = !fr.im_neg && !fr.im_zero;
		if (fr.z[25]) begin
			zc = '0;
		end else if (24'(fr.z) > impmp_pkg::ANGLE_MAX) begin
			zc = impmp_pkg::ANGLE_MAX;
		end else begin
			zc = 24'(fr.z);
		end
		tm = 15'((zc + 24'd256) >> 9);
		if (fr.re_zero) begin
			term = im_pos ? impmp_pkg::DEG_90 : (fr.im_neg ? -impmp_pkg::DEG_90 : '0);
		end else if (fr.im_zero) begin
			term = '0;
		end else if (fr.re_neg != fr.im_neg) begin
			term = -$signed({2'b0, tm});
		end else begin
			term = $signed({2'b0, tm});
		end
		if (!fr.re_neg && !fr.re_zero && im_pos) begin
			phase_w = term;
		end else if (fr.re_neg && im_pos) begin
			phase_w = term + impmp_pkg::DEG_180;
		end else if (fr.re_neg && fr.im_neg) begin
			phase_w = term - impmp_pkg::DEG_180;
		end else begin
			phase_w = term + impmp_pkg::DEG_360;
		end
	end

	assign d_w = {phi_s1, 33'b0} + 90'(plo_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		mag_s1       <= fr.root;
		phase_s1     <= phase_w;
		plo_s1       <= fr.p[32:0] * fr.root;
		phi_s1       <= fr.p[65:33] * fr.root;
		pok_s1       <= fr.p_ok;
		res_s2.mag   <= mag_s1;
		res_s2.phase <= phase_s1;
		res_s2.d     <= d_w;
		// quotient fits 32 bits only above this divisor
		res_s2.ok    <= pok_s1 && (d_w > (90'(1) << 52));
	end

	assign out_vld = vld_s2;
	assign out     = res_s2;

endmodule

// ----- hw/rtl/impmp_div.sv -----
module impmp_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_vld,
	input  impmp_pkg::mul_t    mi,
	output logic               out_vld,
	output impmp_pkg::div_t    out
);

	localparam int NS = impmp_pkg::DIV_STEPS;

	impmp_pkg::div_t src [NS+1];
	impmp_pkg::div_t nxt [NS];
	impmp_pkg::div_t stg_s [NS];
	logic            vld_s [NS];

	always_comb begin
		src[0].mag   = mi.mag;
		src[0].phase = mi.phase;
		src[0].d     = mi.d;
		src[0].ok    = mi.ok;
		src[0].q     = '0;
		// numerator 2^84 with the top 53 quotient bits already known zero
		src[0].r     = 91'(1) << 52;
	end

	for (genvar k = 0; k < NS; k++) begin : g_step
		always_comb begin : step
			impmp_pkg::div_t w;
			logic [90:0]     r2;
			w  = src[k];
			r2 = {w.r[89:0], 1'b0};
			if (r2 >= {1'b0, w.d}) begin
				w.r = r2 - {1'b0, w.d};
				w.q = {w.q[30:0], 1'b1};
			end else begin
				w.r = r2;
				w.q = {w.q[30:0], 1'b0};
			end
			nxt[k] = w;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= (k == 0) ? in_vld : vld_s[(k == 0) ? 0 : k-1];
			end
		end

		always_ff @(posedge clk) begin
			stg_s[k] <= nxt[k];
		end

		assign src[k+1] = stg_s[k];
	end

	assign out_vld = vld_s[NS-1];
	assign out     = src[NS];

endmodule

// ----- hw/rtl/impedance_magnitude_phase.sv -----
// Channel   Direction  Handshake            Payload
// input     in         start / busy         real_part, imag_part, frequency
// result    out        done (one cycle)     raw_magnitude, phase_deg, impedance, overflow
// config    in         cfg_write            cfg_index, cfg_data
//
// One transaction enters per cycle; busy stays low. Each result passes in order through
// 1 entry + FRONT_STAGES (8) + 2 multiply + 32 divide + 1 output register stages,
// among them the 32-stage restoring divider and the 8-stage square root / CORDIC front end.
// Reset clears valid bits and configuration; results cannot be held off.
module impedance_magnitude_phase (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [15:0] real_part,
	input  logic [15:0] imag_part,
	input  logic [16:0] frequency,
	output logic        done,
	output logic [23:0] raw_magnitude,
	output logic [16:0] phase_deg,
	output logic [31:0] impedance,
	output logic        overflow,
	input  logic        cfg_write,
	input  logic [2:0]  cfg_index,
	input  logic [47:0] cfg_data
);

	impmp_pkg::cfg_t   cfg_q;
	logic              fr_vld;
	impmp_pkg::front_t fr;
	logic              mul_vld;
	impmp_pkg::mul_t   mo;
	logic              div_vld;
	impmp_pkg::div_t   dv;
	logic              done_q;
	logic [23:0]       mag_q;
	logic [16:0]       phase_q;
	logic [31:0]       imp_q;
	logic              ovf_q;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				impmp_pkg::REG_CALIBRATED: cfg_q.calibrated      <= cfg_data[0];
				impmp_pkg::REG_CAL_MODE:   cfg_q.cal_mode        <= cfg_data[0];
				impmp_pkg::REG_GAIN:       cfg_q.gain_factor     <= cfg_data;
				impmp_pkg::REG_GAIN_RATE:  cfg_q.gain_rate       <= cfg_data;
				impmp_pkg::REG_START_FREQ: cfg_q.start_frequency <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	impmp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_vld    (start && !busy),
		.real_part (real_part),
		.imag_part (imag_part),
		.frequency (frequency),
		.cfg       (cfg_q),
		.out_vld   (fr_vld),
		.out       (fr)
	);

	impmp_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (fr_vld),
		.fr      (fr),
		.out_vld (mul_vld),
		.out     (mo)
	);

	impmp_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (mul_vld),
		.mi      (mo),
		.out_vld (div_vld),
		.out     (dv)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= div_vld;
		end
	end

	always_ff @(posedge clk) begin
		mag_q   <= dv.mag;
		phase_q <= dv.phase;
		if (!cfg_q.calibrated) begin
			imp_q <= 32'(dv.mag >> 8);
			ovf_q <= 1'b0;
		end else if (dv.ok) begin
			imp_q <= dv.q;
			ovf_q <= 1'b0;
		end else begin
			// saturate on a bad divisor or a quotient past 32 bits
			imp_q <= '1;
			ovf_q <= 1'b1;
		end
	end

	assign done          = done_q;
	assign raw_magnitude = mag_q;
	assign phase_deg     = phase_q;
	assign impedance     = imp_q;
	assign overflow      = ovf_q;

`ifndef ASSERT_OFF
	a_uncal_no_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		done && !cfg_q.calibrated |-> !overflow)
		else $error("overflow set while uncalibrated");

	a_uncal_imp: assert property (@(posedge clk) disable iff (!arst_n)
		done && !cfg_q.calibrated |-> impedance == 32'(raw_magnitude >> 8))
		else $error("uncalibrated impedance differs from magnitude");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($signed(phase_deg) >= -17'sd23040) && ($signed(phase_deg) <= 17'sd57600))
		else $error("phase out of range");
`endif

endmodule
